// ===== sv/scbm_pkg.sv =====
// Shared types, codes and constants for the sound cartridge bank mapper.
`timescale 1ns / 1ps
`default_nettype none

package scbm_pkg;

	localparam int BANK_BYTES = 8192;
	localparam int OFFSET_W   = 13;

	typedef enum logic [1:0] {
		OP_READ  = 2'd0,
		OP_PEEK  = 2'd1,
		OP_WRITE = 2'd2,
		OP_LOAD  = 2'd3
	} op_t;

	localparam logic [2:0] CART_PLAIN     = 3'd0;
	localparam logic [2:0] CART_EXTENDED  = 3'd1;
	localparam logic [2:0] CART_LOW_ONLY  = 3'd2;
	localparam logic [2:0] CART_HIGH_ONLY = 3'd3;
	localparam logic [2:0] CART_MIRRORED  = 3'd4;

	localparam logic [1:0] WIN_NONE   = 2'd0;
	localparam logic [1:0] WIN_COMPAT = 2'd1;
	localparam logic [1:0] WIN_PLUS   = 2'd2;

	localparam logic [1:0] ACC_NONE  = 2'd0;
	localparam logic [1:0] ACC_READ  = 2'd1;
	localparam logic [1:0] ACC_PEEK  = 2'd2;
	localparam logic [1:0] ACC_WRITE = 2'd3;

	localparam logic [15:0] FULL_BASE     = 16'h4000;
	localparam logic [15:0] MODE_ADDR     = 16'hbfff;
	localparam logic [15:0] BANK_REG_MASK = 16'h1800;
	localparam logic [15:0] BANK_REG_HIT  = 16'h1000;
	localparam logic [15:0] COMPAT_LO     = 16'h9800;
	localparam logic [15:0] COMPAT_HI     = 16'ha000;
	localparam logic [15:0] PLUS_LO       = 16'hb800;
	localparam logic [15:0] PLUS_HI       = 16'hc000;
	localparam logic [7:0]  LOW6_MASK     = 8'h3f;
	localparam logic [7:0]  PLUS_BIT      = 8'h80;
	localparam logic [7:0]  RAM2_BITS     = 8'h24;
	localparam logic [7:0]  MODE_EXT      = 8'h20;
	localparam logic [7:0]  ERASED_BYTE   = 8'hff;
	localparam logic [3:0]  MASK_FULL     = 4'hf;
	localparam logic [3:0]  MASK_MIRROR   = 4'h7;

	typedef struct packed {
		logic [1:0]  operation;
		logic [14:0] bus_address;
		logic [7:0]  write_data;
		logic [16:0] load_address;
	} cmd_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic [1:0] sound_access;
		logic [7:0] sound_register;
		logic [7:0] sound_data;
		logic [1:0] sound_mode;
	} rsp_t;

	// Request to the bank memory
	typedef struct packed {
		logic       we;
		logic       re;
		logic [7:0] wdata;
	} mem_cmd_t;

	// Result fields known at decode; read data from the registered memory port joins them at the result register
	typedef struct packed {
		logic       use_mem;
		logic [7:0] rd_const;
		logic [1:0] sound_access;
		logic [7:0] sound_register;
		logic [7:0] sound_data;
		logic [1:0] sound_mode;
	} info_t;

	function automatic logic [3:0] bank_mask(input logic [2:0] cart_type);
		return (cart_type == CART_MIRRORED) ? MASK_MIRROR : MASK_FULL;
	endfunction

	function automatic logic [1:0] window_of(input logic [7:0] mode,
		input logic [7:0] bank2, input logic [7:0] bank3);
		logic [1:0] w;
		if ((mode & MODE_EXT) != 8'h00 && (bank3 & PLUS_BIT) != 8'h00)
			w = WIN_PLUS;
		else if ((mode & MODE_EXT) == 8'h00 && (bank2 & LOW6_MASK) == LOW6_MASK)
			w = WIN_COMPAT;
		else
			w = WIN_NONE;
		return w;
	endfunction

endpackage

`default_nettype wire

// ===== sv/scbm_mem.sv =====
// Bank memory with a clearing pass after reset and a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module scbm_mem #(
	parameter int BANK_COUNT = 16
) (
	input  logic                                             clk,
	input  logic                                             arst_n,
	input  scbm_pkg::mem_cmd_t                               mem_cmd,
	input  logic [$clog2(BANK_COUNT)+scbm_pkg::OFFSET_W-1:0] mem_addr,
	output logic [7:0]                                       rdata,
	output logic                                             busy
);

	localparam int AW        = $clog2(BANK_COUNT) + scbm_pkg::OFFSET_W;
	localparam int MEM_BYTES = BANK_COUNT * scbm_pkg::BANK_BYTES;
	localparam logic [AW-1:0] LAST_ADDR = AW'(MEM_BYTES - 1);

	logic [7:0]    mem [MEM_BYTES];
	logic [AW-1:0] clr_q;
	logic          busy_q;
	logic [7:0]    rdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q  <= '0;
			busy_q <= 1'b1;
		end else if (busy_q) begin
			clr_q <= clr_q + 1'b1;
			if (clr_q == LAST_ADDR)
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q)
			mem[clr_q] <= scbm_pkg::ERASED_BYTE;
		else if (mem_cmd.we)
			mem[mem_addr] <= mem_cmd.wdata;
	end

	// Hold read data until the next read so a stalled stage keeps its byte
	always_ff @(posedge clk) begin
		if (mem_cmd.re)
			rdata_q <= mem[mem_addr];
	end

	assign rdata = rdata_q;
	assign busy  = busy_q;

endmodule

`default_nettype wire

// ===== sv/scbm_ctrl.sv =====
// Mapper registers and access decode: bank, mode, RAM and window state.
`timescale 1ns / 1ps
`default_nettype none

module scbm_ctrl #(
	parameter int BANK_COUNT = 16
) (
	input  logic                                             clk,
	input  logic                                             arst_n,
	input  logic                                             cfg_we,
	input  logic [2:0]                                       cfg_data,
	input  logic                                             accept,
	input  scbm_pkg::cmd_t                                   cmd,
	output scbm_pkg::mem_cmd_t                               mem_cmd,
	output logic [$clog2(BANK_COUNT)+scbm_pkg::OFFSET_W-1:0] mem_addr,
	output scbm_pkg::info_t                                  info
);

	localparam int BW        = $clog2(BANK_COUNT);
	localparam int AW        = BW + scbm_pkg::OFFSET_W;
	localparam int MEM_BYTES = BANK_COUNT * scbm_pkg::BANK_BYTES;

	logic [2:0] cart_type_q;
	logic [7:0] mode_q;
	logic [7:0] bank_q [4];
	logic [3:0] ram_q;
	logic [3:0] mapped_q;
	logic [1:0] win_q;

	scbm_pkg::op_t op;
	logic [15:0]   full;
	logic [1:0]    page;
	logic          in_win;
	logic          is_rd;
	logic          is_mode_wr;
	logic          is_ram_wr;
	logic          is_bank_wr;
	logic          is_snd_wr;
	logic          page_on;
	logic [3:0]    mask;
	logic [3:0]    masked;
	logic [3:0]    bank_red;
	logic [3:0]    new_m;
	logic          new_mapped;
	logic [17:0]   load_red;
	logic [AW-1:0] item_addr;
	logic [7:0]    mode_nxt;
	logic [7:0]    bank2_nxt;
	logic [7:0]    bank3_nxt;
	logic [1:0]    win_nxt;

	always_comb begin
		op      = scbm_pkg::op_t'(cmd.operation);
		full    = 16'(cmd.bus_address) + scbm_pkg::FULL_BASE;
		page    = cmd.bus_address[14:13];
		page_on = mapped_q[page];
		in_win  = (win_q == scbm_pkg::WIN_COMPAT && full >= scbm_pkg::COMPAT_LO &&
				full < scbm_pkg::COMPAT_HI) ||
			(win_q == scbm_pkg::WIN_PLUS && full >= scbm_pkg::PLUS_LO &&
				full < scbm_pkg::PLUS_HI);

		is_rd      = (op == scbm_pkg::OP_READ) || (op == scbm_pkg::OP_PEEK);
		is_mode_wr = (op == scbm_pkg::OP_WRITE) && ((full | 16'h0001) == scbm_pkg::MODE_ADDR);
		is_ram_wr  = (op == scbm_pkg::OP_WRITE) && !is_mode_wr && ram_q[page];
		is_bank_wr = (op == scbm_pkg::OP_WRITE) && !is_mode_wr && !ram_q[page] &&
			((full & scbm_pkg::BANK_REG_MASK) == scbm_pkg::BANK_REG_HIT);
		is_snd_wr  = (op == scbm_pkg::OP_WRITE) && !is_mode_wr && !ram_q[page] &&
			!is_bank_wr && in_win;

		// Bank index: masked value is at most 15, below twice the bank count when BANK_COUNT is at least 8
		mask   = scbm_pkg::bank_mask(cart_type_q);
		masked = bank_q[page][3:0] & mask;
		if (int'(masked) >= BANK_COUNT)
			bank_red = masked - 4'(BANK_COUNT);
		else
			bank_red = masked;
		item_addr = {bank_red[BW-1:0], cmd.bus_address[scbm_pkg::OFFSET_W-1:0]};

		// Preload address: 17 bits, so below twice the memory size when BANK_COUNT is at least 8
		load_red = 18'(cmd.load_address);
		if (load_red >= 18'(MEM_BYTES))
			load_red = load_red - 18'(MEM_BYTES);

		new_m      = cmd.write_data[3:0] & mask;
		new_mapped = (new_m[3] && cart_type_q != scbm_pkg::CART_LOW_ONLY) ||
			(!new_m[3] && cart_type_q != scbm_pkg::CART_HIGH_ONLY);

		mode_nxt  = is_mode_wr ? cmd.write_data : mode_q;
		bank2_nxt = (is_bank_wr && page == 2'd2) ? cmd.write_data : bank_q[2];
		bank3_nxt = (is_bank_wr && page == 2'd3) ? cmd.write_data : bank_q[3];
		win_nxt   = (is_mode_wr || is_bank_wr) ?
			scbm_pkg::window_of(mode_nxt, bank2_nxt, bank3_nxt) : win_q;

		mem_cmd.re    = accept && is_rd && !in_win && page_on;
		mem_cmd.we    = accept && ((op == scbm_pkg::OP_LOAD) || (is_ram_wr && page_on));
		mem_cmd.wdata = cmd.write_data;
		mem_addr      = (op == scbm_pkg::OP_LOAD) ? load_red[AW-1:0] : item_addr;

		info.use_mem  = is_rd && !in_win && page_on;
		info.rd_const = (is_rd && !in_win && !page_on) ? scbm_pkg::ERASED_BYTE : 8'h00;
		if (is_rd && in_win)
			info.sound_access = (op == scbm_pkg::OP_READ) ?
				scbm_pkg::ACC_READ : scbm_pkg::ACC_PEEK;
		else if (is_snd_wr)
			info.sound_access = scbm_pkg::ACC_WRITE;
		else
			info.sound_access = scbm_pkg::ACC_NONE;
		info.sound_register = ((is_rd && in_win) || is_snd_wr) ? full[7:0] : 8'h00;
		info.sound_data     = is_snd_wr ? cmd.write_data : 8'h00;
		info.sound_mode     = win_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cart_type_q <= scbm_pkg::CART_PLAIN;
			mode_q      <= 8'h00;
			bank_q[0]   <= 8'd0;
			bank_q[1]   <= 8'd1;
			bank_q[2]   <= 8'd2;
			bank_q[3]   <= 8'd3;
			ram_q       <= 4'b0000;
			mapped_q    <= 4'b1111;
			win_q       <= scbm_pkg::WIN_NONE;
		end else if (cfg_we) begin
			// New type: reload its mode and mapping defaults
			cart_type_q <= cfg_data;
			mode_q      <= (cfg_data == scbm_pkg::CART_EXTENDED) ? scbm_pkg::MODE_EXT : 8'h00;
			mapped_q    <= (cfg_data == scbm_pkg::CART_HIGH_ONLY) ? 4'b0000 : 4'b1111;
		end else if (accept) begin
			mode_q <= mode_nxt;
			win_q  <= win_nxt;
			if (is_mode_wr) begin
				ram_q[0] <= cmd.write_data[4] | cmd.write_data[0];
				ram_q[1] <= cmd.write_data[4] | cmd.write_data[1];
				ram_q[2] <= cmd.write_data[4] |
					((cmd.write_data & scbm_pkg::RAM2_BITS) == scbm_pkg::RAM2_BITS);
				ram_q[3] <= cmd.write_data[4];
			end
			if (is_bank_wr) begin
				bank_q[page]   <= cmd.write_data;
				mapped_q[page] <= new_mapped;
			end
		end
	end

endmodule

`default_nettype wire

// ===== sv/sound_cartridge_bank_mapper.sv =====
// Top level of the sound cartridge bank mapper: decode, bank memory, result stages.
//
// channel  | valid      | stall      | payload           | accepted when
// ---------+------------+------------+-------------------+--------------------------
// request  | cmd_valid  | cmd_stall  | cmd (cmd_t)       | cmd_valid && !cmd_stall
// result   | res_valid  | res_stall  | res (rsp_t)       | res_valid && !res_stall
// config   | cfg_we     | -          | cfg_data [2:0]    | cfg_we
//
// One request per cycle while cmd_stall is low; each gives exactly one result:
// decode and the memory port register it into the first stage, then the result register takes it.
// After reset the bank memory is cleared one byte a cycle, all BANK_COUNT * 8192 bytes
// (131072 at the default); cmd_stall stays high during the clear.
// A stalled result holds in the result register while one more request is taken
// into the stage behind it; outside the clear, cmd_stall rises only when both are full.
`timescale 1ns / 1ps
`default_nettype none

module sound_cartridge_bank_mapper #(
	parameter int BANK_COUNT = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [2:0]           cfg_data,
	input  logic                 cmd_valid,
	output logic                 cmd_stall,
	input  scbm_pkg::cmd_t       cmd,
	output logic                 res_valid,
	input  logic                 res_stall,
	output scbm_pkg::rsp_t       res
);

	localparam int AW = $clog2(BANK_COUNT) + scbm_pkg::OFFSET_W;

	logic               accept;
	logic               advance;
	logic               mem_busy;
	scbm_pkg::mem_cmd_t mem_cmd;
	logic [AW-1:0]      mem_addr;
	logic [7:0]         mem_rdata;
	scbm_pkg::info_t    info;

	logic               valid_s1;
	scbm_pkg::info_t    info_s1;
	logic               res_valid_q;
	scbm_pkg::rsp_t     res_q;

	assign advance   = valid_s1 && (!res_valid_q || !res_stall);
	assign cmd_stall = mem_busy || (valid_s1 && !advance);
	assign accept    = cmd_valid && !cmd_stall;

	scbm_ctrl #(
		.BANK_COUNT(BANK_COUNT)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.accept   (accept),
		.cmd      (cmd),
		.mem_cmd  (mem_cmd),
		.mem_addr (mem_addr),
		.info     (info)
	);

	scbm_mem #(
		.BANK_COUNT(BANK_COUNT)
	) u_mem (
		.clk      (clk),
		.arst_n   (arst_n),
		.mem_cmd  (mem_cmd),
		.mem_addr (mem_addr),
		.rdata    (mem_rdata),
		.busy     (mem_busy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (accept)
				valid_s1 <= 1'b1;
			else if (advance)
				valid_s1 <= 1'b0;
			if (advance)
				res_valid_q <= 1'b1;
			else if (!res_stall)
				res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			info_s1 <= info;
		if (advance) begin
			res_q.read_data      <= info_s1.use_mem ? mem_rdata : info_s1.rd_const;
			res_q.sound_access   <= info_s1.sound_access;
			res_q.sound_register <= info_s1.sound_register;
			res_q.sound_data     <= info_s1.sound_data;
			res_q.sound_mode     <= info_s1.sound_mode;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	a_no_accept_clear: assert property (@(posedge clk) disable iff (!arst_n)
		mem_busy |-> !accept)
		else $error("request accepted during memory clear");

	a_stage_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(info_s1))
		else $error("waiting stage lost or changed its request");

	a_sound_zero_data: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.sound_access != scbm_pkg::ACC_NONE |-> res.read_data == 8'h00)
		else $error("sound access carries read data");

	a_sound_needs_window: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.sound_access != scbm_pkg::ACC_NONE
		|-> res.sound_mode != scbm_pkg::WIN_NONE)
		else $error("sound access with no open window");

endmodule

`default_nettype wire
